@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the command queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CCF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define CCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

@@ rtl/core/ccf_pkg.sv @@
// ----------------------------------------------------------------------------
// ccf_pkg
// Types, codes and constants shared by the coalescing command queue.
// ----------------------------------------------------------------------------
package ccf_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int COORD_BITS_DEFAULT = 32;

   localparam int MODE_W     = 8;
   localparam int EXTRA_W    = 64;
   localparam int CNT_W      = 5;
   localparam int MAXE_W     = 5;
   localparam int TOL_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [MAXE_W-1:0] MAX_ENTRIES_RESET = 5'd16;
   localparam logic [TOL_W-1:0]  MERGE_TOL_RESET   = 10'd10;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MERGE_TOL   = 2'd1;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_COAL   = 3'd1,
      OP_MANUAL = 3'd2,
      OP_POP    = 3'd3,
      OP_PEEK   = 3'd4,
      OP_CLEAR  = 3'd5,
      OP_PAUSE  = 3'd6
   } opcode_type;

   typedef struct packed {
      logic accept;
      logic check;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic rsp_blocked;
   } dp_status_type;

endpackage

@@ rtl/core/ccf_ctrl.sv @@
// ----------------------------------------------------------------------------
// ccf_ctrl
// Sequencer for the command queue: accept, match check, commit.
// ----------------------------------------------------------------------------
module ccf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output ccf_pkg::ctl_cmd_type  cmd,
   input  ccf_pkg::dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COMMIT
   } state_type;

   state_type state_ff;

   assign req_stall  = (state_ff != ST_IDLE);
   assign cmd.accept = req_valid && (state_ff == ST_IDLE);
   assign cmd.check  = (state_ff == ST_CHECK);
   assign cmd.commit = (state_ff == ST_COMMIT) && !status.rsp_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               // Hold until the response register can take the new word.
               if (!status.rsp_blocked) state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ rtl/core/ccf_dp.sv @@
// ----------------------------------------------------------------------------
// ccf_dp
// Entry storage, pointers, configuration and response register of the queue.
// ----------------------------------------------------------------------------
module ccf_dp #(
   parameter int DEPTH      = ccf_pkg::DEPTH_DEFAULT,
   parameter int COORD_BITS = ccf_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ccf_pkg::ctl_cmd_type                 cmd,
   output ccf_pkg::dp_status_type               status,
   input  logic [2:0]                           req_opcode,
   input  logic [ccf_pkg::MODE_W-1:0]           req_cmd_mode,
   input  logic signed [COORD_BITS-1:0]         req_target_x,
   input  logic signed [COORD_BITS-1:0]         req_target_y,
   input  logic signed [COORD_BITS-1:0]         req_target_z,
   input  logic [ccf_pkg::EXTRA_W-1:0]          req_extra_payload,
   input  logic                                 req_pause_value,
   input  logic                                 csr_we,
   input  logic [ccf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ccf_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic                                 rsp_success,
   output logic                                 rsp_dropped_oldest,
   output logic                                 rsp_coalesced,
   output logic [ccf_pkg::MODE_W-1:0]           rsp_out_mode,
   output logic signed [COORD_BITS-1:0]         rsp_out_x,
   output logic signed [COORD_BITS-1:0]         rsp_out_y,
   output logic signed [COORD_BITS-1:0]         rsp_out_z,
   output logic [ccf_pkg::EXTRA_W-1:0]          rsp_out_extra,
   output logic [ccf_pkg::CNT_W-1:0]            rsp_entry_count,
   output logic                                 rsp_paused_now
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = ccf_pkg::CNT_W;
   localparam int MW    = ccf_pkg::MAXE_W;
   localparam int SUM_W = ((IDX_W > CW) ? IDX_W : CW) + 1;
   localparam int CB    = COORD_BITS;
   localparam int CAP_I = (DEPTH > ((1 << MW) - 1)) ? ((1 << MW) - 1) : DEPTH;
   localparam logic [CW-1:0] CNT_CAP = CW'(CAP_I);

   // Entry storage.
   logic [ccf_pkg::MODE_W-1:0]  mode_mem  [DEPTH];
   logic signed [CB-1:0]        x_mem     [DEPTH];
   logic signed [CB-1:0]        y_mem     [DEPTH];
   logic signed [CB-1:0]        z_mem     [DEPTH];
   logic [ccf_pkg::EXTRA_W-1:0] extra_mem [DEPTH];

   // Pointer and flag state.
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             pause_ff, pause_in;

   // Configuration.
   logic [MW-1:0]               max_ff;
   logic [ccf_pkg::TOL_W-1:0]   tol_ff;

   // Captured request.
   ccf_pkg::opcode_type         op_ff;
   logic [ccf_pkg::MODE_W-1:0]  mode_ff;
   logic signed [CB-1:0]        x_ff, y_ff, z_ff;
   logic [ccf_pkg::EXTRA_W-1:0] extra_ff;
   logic                        pval_ff;

   // Registered memory read.
   logic [ccf_pkg::MODE_W-1:0]  rd_mode_ff;
   logic signed [CB-1:0]        rd_x_ff, rd_y_ff, rd_z_ff;
   logic [ccf_pkg::EXTRA_W-1:0] rd_extra_ff;

   logic match_ff;

   // Response register.
   logic                        rsp_valid_ff;
   logic                        succ_ff, drop_ff, coal_ff;
   logic [ccf_pkg::MODE_W-1:0]  omode_ff;
   logic signed [CB-1:0]        ox_ff, oy_ff, oz_ff;
   logic [ccf_pkg::EXTRA_W-1:0] oextra_ff;
   logic [CW-1:0]               ocount_ff;
   logic                        opause_ff;

   logic                        succ_in, drop_in, coal_in, give_in;
   logic                        mem_we;
   logic [IDX_W-1:0]            wr_slot, rd_slot, tail_slot, last_slot, head_inc;
   logic [CW-1:0]               count_m1, lim;
   logic                        full;
   logic signed [CB:0]          dx, dy, tol_p, tol_n;
   logic                        dx_ok, dy_ok;

   function automatic logic [IDX_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] r;
      r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
      return r[IDX_W-1:0];
   endfunction

   // Slot arithmetic: the count never exceeds DEPTH, so one subtract wraps.
   assign count_m1  = (count_ff == '0) ? '0 : (count_ff - CW'(1));
   assign tail_slot = wrap_slot(SUM_W'(head_ff) + SUM_W'(count_ff));
   assign last_slot = wrap_slot(SUM_W'(head_ff) + SUM_W'(count_m1));
   assign head_inc  = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : (head_ff + IDX_W'(1));
   assign rd_slot   = (ccf_pkg::opcode_type'(req_opcode) == ccf_pkg::OP_COAL) ?
                      last_slot : head_ff;

   // Effective limit: zero acts as one, values above DEPTH act as DEPTH.
   assign lim  = (max_ff == '0) ? CW'(1) : ((CW'(max_ff) > CNT_CAP) ? CNT_CAP : CW'(max_ff));
   assign full = (count_ff >= lim);

   // Horizontal match window: -tol <= d <= tol.
   assign tol_p = $signed({{(CB + 1 - ccf_pkg::TOL_W){1'b0}}, tol_ff});
   assign tol_n = -tol_p;
   assign dx    = $signed({rd_x_ff[CB-1], rd_x_ff}) - $signed({x_ff[CB-1], x_ff});
   assign dy    = $signed({rd_y_ff[CB-1], rd_y_ff}) - $signed({y_ff[CB-1], y_ff});
   assign dx_ok = (dx <= tol_p) && (dx >= tol_n);
   assign dy_ok = (dy <= tol_p) && (dy >= tol_n);

   // Commit decode.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      pause_in = pause_ff;
      succ_in  = 1'b0;
      drop_in  = 1'b0;
      coal_in  = 1'b0;
      give_in  = 1'b0;
      mem_we   = 1'b0;
      wr_slot  = tail_slot;
      unique case (op_ff) inside
         ccf_pkg::OP_PUSH, ccf_pkg::OP_COAL: begin
            succ_in = 1'b1;
            mem_we  = 1'b1;
            if (op_ff == ccf_pkg::OP_COAL && match_ff) begin
               wr_slot = last_slot;
               coal_in = 1'b1;
            end else if (full) begin
               // Dropping the oldest advances head and keeps the count; the new entry takes the old tail slot.
               head_in = head_inc;
               drop_in = 1'b1;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         ccf_pkg::OP_MANUAL: begin
            succ_in  = 1'b1;
            mem_we   = 1'b1;
            wr_slot  = '0;
            head_in  = '0;
            count_in = CW'(1);
         end
         ccf_pkg::OP_POP, ccf_pkg::OP_PEEK: begin
            if (count_ff != '0 && (op_ff == ccf_pkg::OP_PEEK || !pause_ff)) begin
               succ_in = 1'b1;
               give_in = 1'b1;
               if (op_ff == ccf_pkg::OP_POP) begin
                  head_in  = head_inc;
                  count_in = count_ff - CW'(1);
               end
            end
         end
         ccf_pkg::OP_CLEAR: begin
            succ_in  = 1'b1;
            head_in  = '0;
            count_in = '0;
         end
         ccf_pkg::OP_PAUSE: begin
            succ_in  = 1'b1;
            pause_in = pval_ff;
         end
         default: begin
         end
      endcase
   end

   // Storage and read port.
   always_ff @(posedge clock) begin
      if (cmd.commit && mem_we) begin
         mode_mem[wr_slot]  <= mode_ff;
         x_mem[wr_slot]     <= x_ff;
         y_mem[wr_slot]     <= y_ff;
         z_mem[wr_slot]     <= z_ff;
         extra_mem[wr_slot] <= extra_ff;
      end
      if (cmd.accept) begin
         rd_mode_ff  <= mode_mem[rd_slot];
         rd_x_ff     <= x_mem[rd_slot];
         rd_y_ff     <= y_mem[rd_slot];
         rd_z_ff     <= z_mem[rd_slot];
         rd_extra_ff <= extra_mem[rd_slot];
      end
   end

   // Request capture, match result and response payload.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= ccf_pkg::opcode_type'(req_opcode);
         mode_ff  <= req_cmd_mode;
         x_ff     <= req_target_x;
         y_ff     <= req_target_y;
         z_ff     <= req_target_z;
         extra_ff <= req_extra_payload;
         pval_ff  <= req_pause_value;
      end
      if (cmd.check) begin
         match_ff <= (count_ff != '0) && (rd_mode_ff == mode_ff) && dx_ok && dy_ok;
      end
      if (cmd.commit) begin
         succ_ff   <= succ_in;
         drop_ff   <= drop_in;
         coal_ff   <= coal_in;
         omode_ff  <= give_in ? rd_mode_ff : '0;
         ox_ff     <= give_in ? rd_x_ff : '0;
         oy_ff     <= give_in ? rd_y_ff : '0;
         oz_ff     <= give_in ? rd_z_ff : '0;
         oextra_ff <= give_in ? rd_extra_ff : '0;
         ocount_ff <= count_in;
         opause_ff <= pause_in;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         pause_ff     <= 1'b0;
         max_ff       <= ccf_pkg::MAX_ENTRIES_RESET;
         tol_ff       <= ccf_pkg::MERGE_TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            head_ff  <= head_in;
            count_ff <= count_in;
            pause_ff <= pause_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               ccf_pkg::CSR_MAX_ENTRIES: max_ff <= csr_wdata[MW-1:0];
               ccf_pkg::CSR_MERGE_TOL:   tol_ff <= csr_wdata[ccf_pkg::TOL_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.rsp_blocked = rsp_valid_ff && rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_success        = succ_ff;
   assign rsp_dropped_oldest = drop_ff;
   assign rsp_coalesced      = coal_ff;
   assign rsp_out_mode       = omode_ff;
   assign rsp_out_x          = ox_ff;
   assign rsp_out_y          = oy_ff;
   assign rsp_out_z          = oz_ff;
   assign rsp_out_extra      = oextra_ff;
   assign rsp_entry_count    = ocount_ff;
   assign rsp_paused_now     = opause_ff;

endmodule

@@ rtl/core/coalescing_command_fifo.sv @@
// ----------------------------------------------------------------------------
// coalescing_command_fifo
// Bounded queue of flight-target commands with drop-oldest and tail merge.
// ----------------------------------------------------------------------------
// Usage: each request word carries an opcode (push, coalescing push, manual
// push, pop, peek, clear, set pause) together with a full command. Every
// request produces exactly one response word with status flags, the popped
// or peeked command (zero otherwise), the entry count and the pause flag.
// A request is taken on an edge where req_valid is high and req_stall low;
// a response is taken on an edge where rsp_valid is high and rsp_stall low.
// The entry read happens at accept, the match window is evaluated in the
// next cycle, and the commit loads the response register once it is free.
// One request is in flight at a time, so a new request waits until the last
// one has committed; this is set by the registered read of the entry memory
// and the registered match compare that follows it.
// The response register separates the two sides: a new request is accepted
// while the previous response still waits, and only the commit waits when
// the receiver stalls. Configuration writes on the csr_ channel are always
// ready and must be issued while the queue is idle.
// Reset empties the queue, clears the pause flag and loads max_entries 16
// and merge_tolerance 10; entry storage is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module coalescing_command_fifo #(
   parameter int DEPTH      = ccf_pkg::DEPTH_DEFAULT,
   parameter int COORD_BITS = ccf_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_opcode,
   input  logic [ccf_pkg::MODE_W-1:0]           req_cmd_mode,
   input  logic signed [COORD_BITS-1:0]         req_target_x,
   input  logic signed [COORD_BITS-1:0]         req_target_y,
   input  logic signed [COORD_BITS-1:0]         req_target_z,
   input  logic [ccf_pkg::EXTRA_W-1:0]          req_extra_payload,
   input  logic                                 req_pause_value,
   // Response channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_success,
   output logic                                 rsp_dropped_oldest,
   output logic                                 rsp_coalesced,
   output logic [ccf_pkg::MODE_W-1:0]           rsp_out_mode,
   output logic signed [COORD_BITS-1:0]         rsp_out_x,
   output logic signed [COORD_BITS-1:0]         rsp_out_y,
   output logic signed [COORD_BITS-1:0]         rsp_out_z,
   output logic [ccf_pkg::EXTRA_W-1:0]          rsp_out_extra,
   output logic [ccf_pkg::CNT_W-1:0]            rsp_entry_count,
   output logic                                 rsp_paused_now,
   // Configuration write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ccf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ccf_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int CW    = ccf_pkg::CNT_W;
   localparam int CAP_I = (DEPTH > ((1 << ccf_pkg::MAXE_W) - 1)) ?
                          ((1 << ccf_pkg::MAXE_W) - 1) : DEPTH;
   localparam logic [CW-1:0] CNT_CAP = CW'(CAP_I);

   ccf_pkg::ctl_cmd_type   cmd;
   ccf_pkg::dp_status_type status;
   logic                   csr_we;

   // Configuration registers are plain flops, so a write never waits.
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   ccf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ccf_dp #(
      .DEPTH      (DEPTH),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_opcode         (req_opcode),
      .req_cmd_mode       (req_cmd_mode),
      .req_target_x       (req_target_x),
      .req_target_y       (req_target_y),
      .req_target_z       (req_target_z),
      .req_extra_payload  (req_extra_payload),
      .req_pause_value    (req_pause_value),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_success        (rsp_success),
      .rsp_dropped_oldest (rsp_dropped_oldest),
      .rsp_coalesced      (rsp_coalesced),
      .rsp_out_mode       (rsp_out_mode),
      .rsp_out_x          (rsp_out_x),
      .rsp_out_y          (rsp_out_y),
      .rsp_out_z          (rsp_out_z),
      .rsp_out_extra      (rsp_out_extra),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_paused_now     (rsp_paused_now)
   );

   // Only one request may be in flight: an accept makes the block busy.
   `CCF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // A push either merges into the newest entry or may drop the oldest, never both.
   `CCF_ASSERT_IMP(a_merge_drop_excl, clock, reset, rsp_valid, !(rsp_coalesced && rsp_dropped_oldest))
   // The queue never holds more than the largest usable limit.
   `CCF_ASSERT_IMP(a_count_cap, clock, reset, rsp_valid, rsp_entry_count <= CNT_CAP)
   // A failed operation returns no command.
   `CCF_ASSERT_IMP(a_fail_no_data, clock, reset, rsp_valid && !rsp_success, (rsp_out_mode == '0) && (rsp_out_extra == '0) && !rsp_coalesced)

endmodule

@@ tb/coalescing_command_fifo_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_command_fifo_tb
// Self-checking testbench for the coalescing command queue. Request words are
// sent through the valid/stall channel. A model of the queue, kept in this
// file, computes the expected response word for each request as it is
// accepted. Response words are compared in order against those expectations.
// The run starts with directed words, then covers the queue limit and merge
// tolerance corner cases, and ends with phases of random traffic under
// several register settings.
// ----------------------------------------------------------------------------
module coalescing_command_fifo_tb;

   localparam int SLOTS      = ccf_pkg::DEPTH_DEFAULT;
   localparam int COORD_W    = ccf_pkg::COORD_BITS_DEFAULT;
   localparam int MODE_W     = ccf_pkg::MODE_W;
   localparam int EXTRA_W    = ccf_pkg::EXTRA_W;
   localparam int CNT_W      = ccf_pkg::CNT_W;
   localparam int MAXE_W     = ccf_pkg::MAXE_W;
   localparam int TOL_W      = ccf_pkg::TOL_W;
   localparam int CSR_IDX_W  = ccf_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = ccf_pkg::CSR_DATA_W;

   // Opcode seven is not assigned. The queue must answer it with a failed,
   // empty response word and leave its state alone.
   localparam logic [2:0]           OP_SPARE  = 3'd7;
   // Register index with no register behind it. Writes to it must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd2;

   // One request word as it goes out on the req_ ports.
   typedef struct packed {
      logic [2:0]         op;
      logic [MODE_W-1:0]  mode;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [EXTRA_W-1:0] extra;
      logic               pause;
   } command_word_type;

   // One response word. The fields are in the order of the rsp_ ports.
   typedef struct packed {
      logic               success;
      logic               dropped;
      logic               coalesced;
      logic [MODE_W-1:0]  mode;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [EXTRA_W-1:0] extra;
      logic [CNT_W-1:0]   count;
      logic               paused;
   } reply_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid;
   logic                  req_stall;
   logic [2:0]            req_opcode;
   logic [MODE_W-1:0]     req_cmd_mode;
   logic [COORD_W-1:0]    req_target_x;
   logic [COORD_W-1:0]    req_target_y;
   logic [COORD_W-1:0]    req_target_z;
   logic [EXTRA_W-1:0]    req_extra_payload;
   logic                  req_pause_value;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_success;
   logic                  rsp_dropped_oldest;
   logic                  rsp_coalesced;
   logic [MODE_W-1:0]     rsp_out_mode;
   logic [COORD_W-1:0]    rsp_out_x;
   logic [COORD_W-1:0]    rsp_out_y;
   logic [COORD_W-1:0]    rsp_out_z;
   logic [EXTRA_W-1:0]    rsp_out_extra;
   logic [CNT_W-1:0]      rsp_entry_count;
   logic                  rsp_paused_now;

   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow copy of the queue, used to predict the responses.
   command_word_type  slot_cmd [SLOTS];
   int                q_head;
   int                q_fill;
   logic              q_paused;
   logic [MAXE_W-1:0] cap_setting;
   logic [TOL_W-1:0]  merge_window;

   // Expected response words, oldest first.
   reply_word_type pending_replies [$];
   int             mismatches;

   // Idle rates in percent. A rate of zero switches idling off on that side.
   int             send_gap_rate;
   int             stall_rate;
   int             stall_left;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   coalescing_command_fifo u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_cmd_mode       (req_cmd_mode),
      .req_target_x       (req_target_x),
      .req_target_y       (req_target_y),
      .req_target_z       (req_target_z),
      .req_extra_payload  (req_extra_payload),
      .req_pause_value    (req_pause_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_success        (rsp_success),
      .rsp_dropped_oldest (rsp_dropped_oldest),
      .rsp_coalesced      (rsp_coalesced),
      .rsp_out_mode       (rsp_out_mode),
      .rsp_out_x          (rsp_out_x),
      .rsp_out_y          (rsp_out_y),
      .rsp_out_z          (rsp_out_z),
      .rsp_out_extra      (rsp_out_extra),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_paused_now     (rsp_paused_now),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Queue model
   // -------------------------------------------------------------------------

   // Appends a command at the tail. If the queue is at or above its limit, the
   // oldest entry is dropped first. Only one entry is ever dropped, so a limit
   // lowered below the current count leaves the count where it was.
   function automatic logic append_entry(command_word_type c);
      int   cap;
      logic dropped;
      dropped = 1'b0;
      cap = int'(cap_setting);
      if (cap < 1) cap = 1;
      if (cap > SLOTS) cap = SLOTS;
      if (q_fill >= cap && q_fill > 0) begin
         q_head  = (q_head + 1) % SLOTS;
         q_fill -= 1;
         dropped = 1'b1;
      end
      slot_cmd[(q_head + q_fill) % SLOTS] = c;
      q_fill += 1;
      return dropped;
   endfunction

   // Applies one request word to the model and returns the response the
   // queue must give for it.
   function automatic reply_word_type predict_queue_op(command_word_type c);
      reply_word_type r;
      int             tail;
      longint         dx;
      longint         dy;
      r = '0;
      case (c.op) inside
         ccf_pkg::OP_PUSH: begin
            r.dropped = append_entry(c);
            r.success = 1'b1;
         end
         ccf_pkg::OP_COAL: begin
            // The differences are taken at full width, so the two extremes of
            // the coordinate range are far apart and do not wrap.
            tail = (q_head + q_fill + SLOTS - 1) % SLOTS;
            dx = longint'($signed(slot_cmd[tail].x)) - longint'($signed(c.x));
            dy = longint'($signed(slot_cmd[tail].y)) - longint'($signed(c.y));
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (q_fill > 0 && slot_cmd[tail].mode == c.mode &&
                dx <= longint'(merge_window) && dy <= longint'(merge_window)) begin
               slot_cmd[tail] = c;
               r.coalesced    = 1'b1;
            end else begin
               r.dropped = append_entry(c);
            end
            r.success = 1'b1;
         end
         ccf_pkg::OP_MANUAL: begin
            // A flush is not reported as a drop.
            q_head = 0;
            q_fill = 0;
            void'(append_entry(c));
            r.success = 1'b1;
         end
         ccf_pkg::OP_POP, ccf_pkg::OP_PEEK: begin
            if (q_fill > 0 && (c.op == ccf_pkg::OP_PEEK || !q_paused)) begin
               r.success = 1'b1;
               r.mode    = slot_cmd[q_head].mode;
               r.x       = slot_cmd[q_head].x;
               r.y       = slot_cmd[q_head].y;
               r.z       = slot_cmd[q_head].z;
               r.extra   = slot_cmd[q_head].extra;
               if (c.op == ccf_pkg::OP_POP) begin
                  q_head  = (q_head + 1) % SLOTS;
                  q_fill -= 1;
               end
            end
         end
         ccf_pkg::OP_CLEAR: begin
            q_head    = 0;
            q_fill    = 0;
            r.success = 1'b1;
         end
         ccf_pkg::OP_PAUSE: begin
            q_paused  = c.pause;
            r.success = 1'b1;
         end
         default: begin
         end
      endcase
      r.count  = CNT_W'(q_fill);
      r.paused = q_paused;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   function automatic command_word_type make_cmd(input logic [2:0] op,
                                                 input logic [MODE_W-1:0] mode,
                                                 input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y,
                                                 input logic [COORD_W-1:0] z,
                                                 input logic pause);
      command_word_type c;
      c.op    = op;
      c.mode  = mode;
      c.x     = x;
      c.y     = y;
      c.z     = z;
      c.extra = {$urandom, $urandom};
      c.pause = pause;
      return c;
   endfunction

   // Coordinates are mostly full-range random. Small values and the two
   // extremes are mixed in.
   function automatic logic [COORD_W-1:0] roll_coord();
      case ($urandom_range(0, 5))
         0:       return {1'b0, {(COORD_W-1){1'b1}}};
         1:       return {1'b1, {(COORD_W-1){1'b0}}};
         2:       return COORD_W'($urandom_range(0, 4000)) - COORD_W'(2000);
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // Moves a coordinate by up to two steps beyond the merge window on either
   // side, so that the tolerance boundary is hit often.
   function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] base);
      int span;
      int off;
      span = int'(merge_window) + 2;
      off  = int'($urandom_range(0, 2 * span)) - span;
      return base + COORD_W'(off);
   endfunction

   // Draws one random request word. Most coalescing pushes aim close to the
   // newest entry, so both merges and near misses are common. The rest of the
   // traffic mixes in plain pushes, pops, peeks, flushes and pause changes.
   function automatic command_word_type roll_command();
      command_word_type c;
      int               k;
      int               tail;
      c = make_cmd(ccf_pkg::OP_PUSH, MODE_W'($urandom), roll_coord(), roll_coord(),
                   roll_coord(), 1'b0);
      c.pause = q_paused ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 2) == 0);
      k = $urandom_range(0, 99);
      if (k < 22)      c.op = ccf_pkg::OP_PUSH;
      else if (k < 52) c.op = ccf_pkg::OP_COAL;
      else if (k < 55) c.op = ccf_pkg::OP_MANUAL;
      else if (k < 75) c.op = ccf_pkg::OP_POP;
      else if (k < 85) c.op = ccf_pkg::OP_PEEK;
      else if (k < 88) c.op = ccf_pkg::OP_CLEAR;
      else if (k < 97) c.op = ccf_pkg::OP_PAUSE;
      else             c.op = OP_SPARE;
      if (c.op == ccf_pkg::OP_COAL && q_fill > 0 && $urandom_range(0, 9) < 8) begin
         tail = (q_head + q_fill + SLOTS - 1) % SLOTS;
         if ($urandom_range(0, 3) != 0) c.mode = slot_cmd[tail].mode;
         c.x = nudge(slot_cmd[tail].x);
         c.y = nudge(slot_cmd[tail].y);
      end
      return c;
   endfunction

   // Sends one request word and waits until it is accepted. The expected
   // response is recorded at the edge that accepts it. Valid stays high
   // afterwards, so a following word goes out back to back. Otherwise a random
   // idle burst lowers it.
   task automatic send_word(command_word_type c);
      reply_word_type expect_word;
      req_valid         <= 1'b1;
      req_opcode        <= c.op;
      req_cmd_mode      <= c.mode;
      req_target_x      <= c.x;
      req_target_y      <= c.y;
      req_target_z      <= c.z;
      req_extra_payload <= c.extra;
      req_pause_value   <= c.pause;
      do @(posedge clock); while (req_stall);
      expect_word = predict_queue_op(c);
      pending_replies.insert(pending_replies.size(), expect_word);
      if (send_gap_rate != 0 && $urandom_range(0, 99) < send_gap_rate) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every expected response has arrived. It then
   // waits on, so that the queue is idle afterwards.
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes both registers. The upper data bits carry random values that the
   // queue must ignore. The unused index can also be written.
   task automatic program_csr(input logic [MAXE_W-1:0] cap,
                              input logic [TOL_W-1:0] window,
                              input bit poke_spare);
      csr_valid <= 1'b1;
      csr_index <= ccf_pkg::CSR_MAX_ENTRIES;
      csr_wdata <= {(CSR_DATA_W-MAXE_W)'($urandom), cap};
      do @(posedge clock); while (!csr_ready);
      cap_setting = cap;
      csr_index <= ccf_pkg::CSR_MERGE_TOL;
      csr_wdata <= {(CSR_DATA_W-TOL_W)'($urandom), window};
      do @(posedge clock); while (!csr_ready);
      merge_window = window;
      if (poke_spare) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= CSR_DATA_W'($urandom);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Prints one response word on two lines.
   task automatic show_reply(input string tag, input reply_word_type w);
      $display("  %s ok=%b drop=%b merge=%b mode=%h cnt=%0d pause=%b",
               tag, w.success, w.dropped, w.coalesced, w.mode, w.count, w.paused);
      $display("  %s x=%h y=%h z=%h extra=%h", tag, w.x, w.y, w.z, w.extra);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: random stall bursts and the response check
   // -------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || stall_rate == 0) begin
         rsp_stall  <= 1'b0;
         stall_left  = 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left  = stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_rate) begin
         rsp_stall  <= 1'b1;
         stall_left  = $urandom_range(0, 8);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Every accepted response word is compared in full against the oldest
   // expectation. Only the first ten failures are printed.
   always @(posedge clock) begin
      reply_word_type seen;
      reply_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_success, rsp_dropped_oldest, rsp_coalesced, rsp_out_mode,
                 rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_extra,
                 rsp_entry_count, rsp_paused_now};
         if (pending_replies.size() == 0) begin
            mismatches += 1;
            if (mismatches <= 10)
               $display("%t: response word with no request waiting", $realtime);
         end else begin
            want = pending_replies.pop_front();
            if (seen !== want) begin
               mismatches += 1;
               if (mismatches <= 10) begin
                  $display("%t: response mismatch", $realtime);
                  show_reply("expected", want);
                  show_reply("actual  ", seen);
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Directed words at the reset settings (limit 16, tolerance 10). They cover
   // every opcode, the coordinate extremes, the merge boundary on both axes, a
   // mode mismatch, pause blocking pops but not peeks, a manual push that
   // flushes entries, and reads of an empty queue.
   task automatic test_basic_ops();
      command_word_type c;
      send_gap_rate = 20;
      stall_rate    = 20;
      send_word(make_cmd(ccf_pkg::OP_POP,  8'h00, '0, '0, '0, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_PEEK, 8'h00, '0, '0, '0, 1'b1));
      send_word(make_cmd(OP_SPARE, 8'hA5, '1, '1, '1, 1'b1));
      // Newest x at the positive extreme. The next x is at the negative
      // extreme, which is far away and must not merge.
      c = make_cmd(ccf_pkg::OP_PUSH, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'hFFFF_FFFF, 1'b0);
      c.extra = '1;
      send_word(c);
      send_word(make_cmd(ccf_pkg::OP_COAL, 8'hFF, 32'h8000_0000, 32'h8000_0000,
                         32'h1, 1'b0));
      // Exactly at the tolerance: merges and replaces the whole entry.
      send_word(make_cmd(ccf_pkg::OP_COAL, 8'hFF, 32'h8000_000A, 32'h8000_0000,
                         32'h2, 1'b0));
      // One millimeter past the tolerance: appends.
      send_word(make_cmd(ccf_pkg::OP_COAL, 8'hFF, 32'h8000_0015, 32'h8000_0000,
                         32'h3, 1'b0));
      // Same position but another mode: appends.
      c = make_cmd(ccf_pkg::OP_COAL, 8'h00, 32'h8000_0015, 32'h8000_0000, 32'h0, 1'b0);
      c.extra = '0;
      send_word(c);
      // Tolerance reached on both axes at once, in opposite directions.
      send_word(make_cmd(ccf_pkg::OP_COAL, 8'h00, 32'h8000_000B, 32'h8000_000A,
                         32'h4, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_PAUSE, 8'h00, '0, '0, '0, 1'b1));
      send_word(make_cmd(ccf_pkg::OP_POP,   8'h00, '0, '0, '0, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_PEEK,  8'h00, '0, '0, '0, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_POP,   8'h00, '0, '0, '0, 1'b1));
      send_word(make_cmd(ccf_pkg::OP_PAUSE, 8'hFF, '1, '1, '1, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_POP,   8'h00, '0, '0, '0, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_PEEK,  8'h00, '0, '0, '0, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_MANUAL, 8'h5A, 32'h1234_5678, 32'hEDCB_A988,
                         32'h0, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_PEEK,  8'h00, '0, '0, '0, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_POP,   8'h00, '0, '0, '0, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_POP,   8'h00, '0, '0, '0, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_PUSH,  8'h01, 32'd10, 32'd20, 32'd30, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_CLEAR, 8'h00, '0, '0, '0, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_PEEK,  8'h00, '0, '0, '0, 1'b0));
      // A coalescing push into an empty queue has nothing to merge with.
      send_word(make_cmd(ccf_pkg::OP_COAL,  8'h01, 32'd10, 32'd20, 32'd30, 1'b0));
      drain_replies();
   endtask

   // Queue limit and merge tolerance at their extremes: limit 1 with exact
   // match only, limit 0 acting as 1, limit above the depth acting as the
   // depth with the tolerance at its top, and a limit lowered below the
   // current count.
   task automatic test_queue_limits();
      send_gap_rate = 30;
      stall_rate    = 30;

      program_csr(5'd1, 10'd0, 1'b0);
      repeat (3) send_word(make_cmd(ccf_pkg::OP_PUSH, 8'h11, 32'd100, 32'd200,
                                    32'd300, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_COAL, 8'h11, 32'd100, 32'd200, 32'd301, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_COAL, 8'h11, 32'd101, 32'd200, 32'd302, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_POP,  8'h00, '0, '0, '0, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_POP,  8'h00, '0, '0, '0, 1'b0));
      drain_replies();

      program_csr(5'd0, 10'd1000, 1'b0);
      send_word(make_cmd(ccf_pkg::OP_PUSH, 8'h22, 32'd0, 32'd0, 32'd7, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_PUSH, 8'h22, 32'd0, 32'd0, 32'd8, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_COAL, 8'h22, 32'd1000, -32'sd1000, 32'd9, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_COAL, 8'h22, 32'd2001, -32'sd1000, 32'd9, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_PEEK, 8'h00, '0, '0, '0, 1'b0));
      drain_replies();

      // The unused register index is written too. It must change nothing.
      program_csr(5'd31, 10'd1023, 1'b1);
      repeat (17) send_word(make_cmd(ccf_pkg::OP_PUSH, MODE_W'($urandom), roll_coord(),
                                     roll_coord(), roll_coord(), 1'b0));
      send_word(make_cmd(ccf_pkg::OP_PUSH, 8'h42, 32'd5000, -32'sd5000, 32'd1, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_PEEK, 8'h00, '0, '0, '0, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_COAL, 8'h42, 32'd6023, -32'sd6023, 32'd2, 1'b0));
      send_word(make_cmd(ccf_pkg::OP_COAL, 8'h42, 32'd7047, -32'sd6023, 32'd3, 1'b0));
      drain_replies();

      // The queue is full at 16 entries. Under a limit of 3, each push drops
      // a single entry, so the count does not go down.
      program_csr(5'd3, 10'd10, 1'b0);
      send_word(make_cmd(ccf_pkg::OP_PUSH, 8'h33, roll_coord(), roll_coord(),
                         roll_coord(), 1'b0));
      send_word(make_cmd(ccf_pkg::OP_COAL, 8'h34, roll_coord(), roll_coord(),
                         roll_coord(), 1'b0));
      repeat (17) send_word(make_cmd(ccf_pkg::OP_POP, 8'h00, '0, '0, '0, 1'b0));
      drain_replies();
   endtask

   // Random traffic in five phases. Each phase has its own register setting
   // and idle pattern. The last phase runs with no idling on either side.
   task automatic test_random_traffic();
      logic [MAXE_W-1:0] cap;
      logic [TOL_W-1:0]  window;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin cap = 5'd16; window = 10'd10;   send_gap_rate = 25; stall_rate = 25; end
            1: begin cap = 5'd3;  window = 10'd0;    send_gap_rate = 50; stall_rate = 10; end
            2: begin cap = 5'd0;  window = 10'd1023; send_gap_rate = 0;  stall_rate = 0;  end
            3: begin cap = 5'd31; window = 10'd1000; send_gap_rate = 15; stall_rate = 50; end
            default: begin
               cap = MAXE_W'($urandom);
               window = TOL_W'($urandom);
               send_gap_rate = 0;
               stall_rate = 0;
            end
         endcase
         program_csr(cap, window, 1'b0);
         repeat (115) send_word(roll_command());
         drain_replies();
      end
   endtask

   // -------------------------------------------------------------------------
   // Run control
   // -------------------------------------------------------------------------

   initial begin
      req_valid         <= 1'b0;
      req_opcode        <= ccf_pkg::OP_PUSH;
      req_cmd_mode      <= '0;
      req_target_x      <= '0;
      req_target_y      <= '0;
      req_target_z      <= '0;
      req_extra_payload <= '0;
      req_pause_value   <= 1'b0;
      csr_valid         <= 1'b0;
      csr_index         <= ccf_pkg::CSR_MAX_ENTRIES;
      csr_wdata         <= '0;
      q_head        = 0;
      q_fill        = 0;
      q_paused      = 1'b0;
      cap_setting   = ccf_pkg::MAX_ENTRIES_RESET;
      merge_window  = ccf_pkg::MERGE_TOL_RESET;
      mismatches    = 0;
      send_gap_rate = 0;
      stall_rate    = 0;
      stall_left    = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_queue_limits();
      test_random_traffic();

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // A correct run takes well under a tenth of this time.
   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
